@@ hdl/ssfe_pkg.sv @@
// ----------------------------------------------------------------------------
// ssfe_pkg
// Types and fixed constants shared by the string field extractor modules.
// ----------------------------------------------------------------------------
package ssfe_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_TABLE_LENGTH    = 2'd0;
   localparam logic [1:0] CSR_STRUCTURE_COUNT = 2'd1;
   localparam logic [1:0] CSR_WANTED_TYPE     = 2'd2;
   localparam logic [1:0] CSR_FIELD_OFFSET    = 2'd3;

   localparam int CSR_DATA_W = 16;

   // register values after reset
   localparam logic [7:0] RESET_WANTED_TYPE  = 8'd3;
   localparam logic [7:0] RESET_FIELD_OFFSET = 8'd8;

   // walk phases
   localparam logic [1:0] PH_FORMATTED = 2'd0;
   localparam logic [1:0] PH_COLLECT   = 2'd1;
   localparam logic [1:0] PH_SKIP      = 2'd2;

   // result status codes
   localparam logic [1:0] ST_BYTE     = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   // answer event kinds
   localparam logic [1:0] EVT_NOTFOUND = 2'd0;
   localparam logic [1:0] EVT_EMPTY    = 2'd1;
   localparam logic [1:0] EVT_STRING   = 2'd2;

   localparam logic [7:0] MIN_LENGTH = 8'd4;

   // buffer fill counter, wide enough for fill counts up to 127
   localparam int FILL_W = 7;

   // output queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [7:0] table_byte;
      logic       first_of_table;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] char_value;
      logic [1:0] status;
      logic       is_last;
      logic       truncated;
   } rsp_payload_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic [FILL_W-1:0] fill;
      logic              cut;
   } evt_type;

   typedef struct packed {
      logic              en;
      logic [FILL_W-1:0] addr;
      logic [7:0]        data;
   } buf_wr_type;

endpackage

@@ hdl/ssfe_stream_if.sv @@
// ----------------------------------------------------------------------------
// ssfe_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ssfe_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

@@ hdl/smbios_string_field_extract_core.sv @@
// ----------------------------------------------------------------------------
// smbios_string_field_extract_core
// Looks up one string field of an SMBIOS structure table streamed byte-wise.
// ----------------------------------------------------------------------------
// Usage
//   req_if carries one table byte per transfer; first_of_table restarts the
//   walk at that byte. rsp_if returns the answer: the string bytes (is_last
//   on the final one, truncated on all when the string was cut), or a single
//   empty-string or not-found status item. One answer per table.
//   csr_we/csr_index/csr_wdata write table_length, structure_count,
//   wanted_type and field_offset; write them only while the block is idle.
// Timing
//   Table bytes are taken at one per cycle while req_if ready is high; an
//   answer event holds req_if off while it is raised. A status item reaches
//   rsp_if through the event register and the result queue. A string answer
//   passes the event register, the player and the buffer read register, then
//   streams one byte per cycle out of the string buffer while the queue has
//   room; req_if is held off until the last read has been issued.
// Reset and stalls
//   Reset clears the walk, the player and the result queue; the buffer
//   contents are not cleared. A stalled rsp_if fills the four-entry result
//   queue, after which string playback and req_if ready hold.
// ----------------------------------------------------------------------------
module smbios_string_field_extract_core #(
   parameter int STRING_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   ssfe_stream_if.sink   req_if,
   ssfe_stream_if.source rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import ssfe_pkg::*;

   evt_type         evt;
   buf_wr_type      wr;
   logic            req_room;
   logic            req_accept;
   logic            rsp_valid;
   rsp_payload_type rsp_item;

   // a byte transfers when both sides agree
   assign req_if.ready = req_room;
   assign req_accept   = req_if.valid && req_room;

   // walk the table, fill the string buffer, raise the answer event
   ssfe_parser #(
      .STRING_MAX (STRING_MAX)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_accept  (req_accept),
      .req_payload (req_if.payload),
      .evt         (evt),
      .wr          (wr)
   );

   // hold the buffer, play the answer back, queue results
   ssfe_replay #(
      .STRING_MAX (STRING_MAX)
   ) u_replay (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .wr        (wr),
      .rsp_pop   (rsp_valid && rsp_if.ready),
      .req_room  (req_room),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_item;

endmodule

@@ hdl/ssfe_parser.sv @@
// ----------------------------------------------------------------------------
// ssfe_parser
// Walks the structure table one byte per transfer, writes the wanted string
// into the string buffer and raises one answer event per table.
// ----------------------------------------------------------------------------
module ssfe_parser #(
   parameter int STRING_MAX = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_wdata,
   input  logic                        req_accept,
   input  ssfe_pkg::req_payload_type   req_payload,
   output ssfe_pkg::evt_type           evt,
   output ssfe_pkg::buf_wr_type        wr
);
   import ssfe_pkg::*;

   localparam logic [FILL_W-1:0] FILL_CAP = FILL_W'(STRING_MAX);

   logic [15:0] table_length_ff;
   logic [15:0] structure_count_ff;
   logic [7:0]  wanted_type_ff;
   logic [7:0]  field_offset_ff;

   logic [1:0]        phase_ff,     phase_in;
   logic [15:0]       table_pos_ff, table_pos_in;
   logic [15:0]       seen_ff,      seen_in;
   logic [7:0]        pos_in_ff,    pos_in_in;
   logic [7:0]        type_ff,      type_in;
   logic [7:0]        length_ff,    length_in;
   logic [7:0]        wanted_ff,    wanted_in;
   logic              cand_ff,      cand_in;
   logic              prev_zero_ff, prev_zero_in;
   logic [7:0]        done_ff,      done_in;
   logic [FILL_W-1:0] fill_ff,      fill_in;
   logic              cut_ff,       cut_in;
   logic              answered_ff,  answered_in;
   evt_type           evt_ff,       evt_in;

   logic [7:0]  b;
   logic [15:0] pos_cur;
   logic        restart;
   logic        first_str;
   logic        at_start;
   logic        terminator;
   logic        answer_now;
   logic [8:0]  cur_string;

   assign b       = req_payload.table_byte;
   assign restart = req_accept && req_payload.first_of_table;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff    <= '0;
         structure_count_ff <= '0;
         wanted_type_ff     <= RESET_WANTED_TYPE;
         field_offset_ff    <= RESET_FIELD_OFFSET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TABLE_LENGTH:    table_length_ff    <= csr_wdata;
            CSR_STRUCTURE_COUNT: structure_count_ff <= csr_wdata;
            CSR_WANTED_TYPE:     wanted_type_ff     <= csr_wdata[7:0];
            CSR_FIELD_OFFSET:    field_offset_ff    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      // restart values take effect for the byte that carries the mark
      phase_in     = restart ? PH_FORMATTED : phase_ff;
      table_pos_in = restart ? '0 : table_pos_ff;
      seen_in      = restart ? '0 : seen_ff;
      pos_in_in    = restart ? '0 : pos_in_ff;
      type_in      = restart ? '0 : type_ff;
      length_in    = restart ? '0 : length_ff;
      wanted_in    = restart ? '0 : wanted_ff;
      cand_in      = restart ? 1'b0 : cand_ff;
      prev_zero_in = restart ? 1'b0 : prev_zero_ff;
      done_in      = restart ? '0 : done_ff;
      fill_in      = restart ? '0 : fill_ff;
      cut_in       = restart ? 1'b0 : cut_ff;
      answered_in  = restart ? 1'b0 : answered_ff;

      evt_in     = '0;
      wr         = '0;
      pos_cur    = table_pos_in;
      first_str  = 1'b0;
      at_start   = 1'b0;
      terminator = 1'b0;
      answer_now = 1'b0;
      cur_string = 9'({1'b0, done_in} + 9'd1);

      if (req_accept && !answered_in) begin
         if (pos_cur >= table_length_ff) begin
            evt_in.valid = 1'b1;
            evt_in.kind  = EVT_NOTFOUND;
            answered_in  = 1'b1;
         end else if (phase_in == PH_FORMATTED && pos_in_in == 8'd0 &&
                      (seen_in >= structure_count_ff ||
                       ({1'b0, pos_cur} + 17'd4) > {1'b0, table_length_ff})) begin
            // all structures seen or no room for another structure
            evt_in.valid = 1'b1;
            evt_in.kind  = EVT_NOTFOUND;
            answered_in  = 1'b1;
         end else begin
            table_pos_in = pos_cur + 16'd1;
            if (phase_in == PH_FORMATTED) begin
               if (pos_in_in == 8'd0) begin
                  type_in = b;
               end
               if (pos_in_in == 8'd1) begin
                  length_in = (b < MIN_LENGTH) ? MIN_LENGTH : b;
                  cand_in   = (type_in == wanted_type_ff) && (length_in > field_offset_ff);
               end
               if (pos_in_in == field_offset_ff) begin
                  wanted_in = b;
               end
               pos_in_in = pos_in_in + 8'd1;
               // formatted area ends: move to the string set
               if (pos_in_in != 8'd1 && ({1'b0, pos_in_in} >= {1'b0, length_in})) begin
                  phase_in     = (cand_in && wanted_in != 8'd0) ? PH_COLLECT : PH_SKIP;
                  pos_in_in    = '0;
                  prev_zero_in = 1'b0;
                  done_in      = '0;
                  fill_in      = '0;
                  cut_in       = 1'b0;
               end
            end else begin
               first_str  = (pos_in_in == 8'd0);
               at_start   = first_str || prev_zero_in;
               terminator = !first_str && prev_zero_in && b == 8'd0;
               if (phase_in == PH_COLLECT) begin
                  if (at_start && b == 8'd0) begin
                     fill_in  = '0;
                     phase_in = PH_SKIP;
                  end else if (cur_string == {1'b0, wanted_in}) begin
                     if (b == 8'd0) begin
                        phase_in = PH_SKIP;
                     end else if (fill_in < FILL_CAP) begin
                        wr.en   = 1'b1;
                        wr.addr = fill_in;
                        wr.data = b;
                        fill_in = fill_in + 1'b1;
                     end else begin
                        cut_in = 1'b1;
                     end
                  end else if (b == 8'd0) begin
                     done_in = done_in + 8'd1;
                  end
               end
               prev_zero_in = (b == 8'd0);
               pos_in_in    = 8'd1;
               if (terminator) begin
                  seen_in = seen_in + 16'd1;
                  if (cand_in) begin
                     answer_now   = 1'b1;
                     evt_in.valid = 1'b1;
                     evt_in.kind  = (fill_in == '0) ? EVT_EMPTY : EVT_STRING;
                     evt_in.fill  = fill_in;
                     evt_in.cut   = cut_in;
                     answered_in  = 1'b1;
                  end else begin
                     phase_in  = PH_FORMATTED;
                     pos_in_in = '0;
                     cand_in   = 1'b0;
                  end
               end
            end
            // last table byte without an answer
            if (!answer_now && ({1'b0, pos_cur} + 17'd1) >= {1'b0, table_length_ff}) begin
               evt_in.valid = 1'b1;
               evt_in.kind  = EVT_NOTFOUND;
               evt_in.fill  = '0;
               evt_in.cut   = 1'b0;
               answered_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FORMATTED;
         table_pos_ff <= '0;
         seen_ff      <= '0;
         pos_in_ff    <= '0;
         type_ff      <= '0;
         length_ff    <= '0;
         wanted_ff    <= '0;
         cand_ff      <= 1'b0;
         prev_zero_ff <= 1'b0;
         done_ff      <= '0;
         fill_ff      <= '0;
         cut_ff       <= 1'b0;
         answered_ff  <= 1'b0;
         evt_ff       <= '0;
      end else begin
         evt_ff <= evt_in;
         if (req_accept) begin
            phase_ff     <= phase_in;
            table_pos_ff <= table_pos_in;
            seen_ff      <= seen_in;
            pos_in_ff    <= pos_in_in;
            type_ff      <= type_in;
            length_ff    <= length_in;
            wanted_ff    <= wanted_in;
            cand_ff      <= cand_in;
            prev_zero_ff <= prev_zero_in;
            done_ff      <= done_in;
            fill_ff      <= fill_in;
            cut_ff       <= cut_in;
            answered_ff  <= answered_in;
         end
      end
   end

   assign evt = evt_ff;

endmodule

@@ hdl/ssfe_replay.sv @@
// ----------------------------------------------------------------------------
// ssfe_replay
// Holds the string buffer memory, plays a found string back one byte per
// cycle while the queue has room and queues items for the result channel.
// ----------------------------------------------------------------------------
module ssfe_replay #(
   parameter int STRING_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ssfe_pkg::evt_type          evt,
   input  ssfe_pkg::buf_wr_type       wr,
   input  logic                       rsp_pop,
   output logic                       req_room,
   output logic                       rsp_valid,
   output ssfe_pkg::rsp_payload_type  rsp_item
);
   import ssfe_pkg::*;

   localparam int ADDR_W = (STRING_MAX > 1) ? $clog2(STRING_MAX) : 1;

   logic [7:0] mem [STRING_MAX];

   logic              active_ff,   active_in;
   logic [FILL_W-1:0] rd_idx_ff,   rd_idx_in;
   logic [FILL_W-1:0] fill_ff,     fill_in;
   logic              cut_ff,      cut_in;
   logic              inflight_ff;
   logic              infl_last_ff;
   logic [7:0]        rdata_ff;

   rsp_payload_type       fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] head_ff, head_in;
   logic [FIFO_PTR_W-1:0] tail_ff, tail_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   logic                  issue;
   logic                  issue_last;
   logic                  push;
   rsp_payload_type       push_item;
   logic [FIFO_CNT_W-1:0] occupied;

   assign occupied   = count_ff + FIFO_CNT_W'(inflight_ff);
   assign issue      = active_ff && (occupied < FIFO_CNT_W'(FIFO_DEPTH));
   assign issue_last = (rd_idx_ff + 1'b1) == fill_ff;

   // take a new byte only with the player idle, no event pending and a queue slot free
   assign req_room = !active_ff && !evt.valid && (occupied < FIFO_CNT_W'(FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff     <= mem[rd_idx_ff[ADDR_W-1:0]];
         infl_last_ff <= issue_last;
      end
   end

   always_comb begin
      active_in = active_ff;
      rd_idx_in = rd_idx_ff;
      fill_in   = fill_ff;
      cut_in    = cut_ff;
      if (evt.valid && evt.kind == EVT_STRING) begin
         active_in = 1'b1;
         rd_idx_in = '0;
         fill_in   = evt.fill;
         cut_in    = evt.cut;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
         if (issue_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_comb begin
      push_item = '0;
      push      = 1'b0;
      if (inflight_ff) begin
         push                 = 1'b1;
         push_item.char_value = rdata_ff;
         push_item.status     = ST_BYTE;
         push_item.is_last    = infl_last_ff;
         push_item.truncated  = cut_ff;
      end else if (evt.valid && evt.kind != EVT_STRING) begin
         push              = 1'b1;
         push_item.status  = (evt.kind == EVT_EMPTY) ? ST_EMPTY : ST_NOTFOUND;
         push_item.is_last = 1'b1;
      end
      head_in  = rsp_pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[tail_ff] <= push_item;
      end
      fill_ff <= fill_in;
      cut_ff  <= cut_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         rd_idx_ff   <= '0;
         inflight_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         active_ff   <= active_in;
         rd_idx_ff   <= rd_idx_in;
         inflight_ff <= issue;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = fifo_ff[head_ff];

endmodule
